### sv/polyline_length_table_defines.svh
// ----------------------------------------------------------------------------
// Polyline length table assertion macros
// Shared assertion forms for the polyline length table modules.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_LENGTH_TABLE_DEFINES_SVH
`define POLYLINE_LENGTH_TABLE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PLT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define PLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/plt_pkg.sv
// ----------------------------------------------------------------------------
// Polyline length table package
// Constants, types and command structures shared by the controller and datapath.
// ----------------------------------------------------------------------------
package plt_pkg;

   localparam int MaxPoints = 256;
   localparam int IdxW      = $clog2(MaxPoints);
   localparam int CntW      = IdxW + 1;
   localparam int CoordW    = 24;
   localparam int SegW      = 25;
   localparam int TotW      = 33;
   localparam int SqW       = 50;
   localparam int RootSteps = SqW / 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PLACE,
      ST_SEG_START,
      ST_RD_A,
      ST_RD_B,
      ST_CAP_B,
      ST_DIFF,
      ST_SQ,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_ACC,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic            load;      // capture input word
      logic            shift_rd;  // read entry idx (one below the shift target)
      logic            shift_wr;  // write read data to entry idx
      logic            place;     // write new vertex at idx
      logic            rd_vertex; // read vertex at idx
      logic            cap_a;     // capture read data as first vertex
      logic            cap_b;     // capture read data as second vertex
      logic            diff;
      logic            square;
      logic            root_start;
      logic            root_step;
      logic            acc;
      logic            clr_sum;
      logic            inc_count;
      logic            full;
      logic            publish;   // load the result word into the output register
      logic [IdxW-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic            root_done;
   } status_type;

endpackage

### sv/plt_datapath.sv
// ----------------------------------------------------------------------------
// Polyline length table datapath
// Vertex memories, difference and squaring stages, serial square root and sum.
// ----------------------------------------------------------------------------
module plt_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  plt_pkg::cmd_type              cmd,
   output plt_pkg::status_type           status,
   input  logic signed [plt_pkg::CoordW-1:0] req_point_x,
   input  logic signed [plt_pkg::CoordW-1:0] req_point_y,
   output logic [plt_pkg::TotW-1:0]      sum_out,
   output logic                          full_out
);

   logic signed [plt_pkg::CoordW-1:0] mem_x [plt_pkg::MaxPoints];
   logic signed [plt_pkg::CoordW-1:0] mem_y [plt_pkg::MaxPoints];

   logic signed [plt_pkg::CoordW-1:0] new_x_ff, new_y_ff, rd_x_ff, rd_y_ff;
   logic signed [plt_pkg::CoordW-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [plt_pkg::CoordW:0]          dx_ff, dy_ff;
   logic [plt_pkg::SqW-1:0]           sq_ff, rem_ff, rem_in;
   logic [plt_pkg::SqW-1:0]           root_ff, root_in, bit_ff;
   logic [plt_pkg::TotW-1:0]          sum_ff, out_total_ff;
   logic                              full_ff, out_full_ff;
   logic signed [plt_pkg::CoordW:0]   ddx, ddy;
   logic [5:0]                        steps_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         new_x_ff <= req_point_x;
         new_y_ff <= req_point_y;
      end
      if (cmd.shift_rd || cmd.rd_vertex) begin
         rd_x_ff <= mem_x[cmd.idx];
         rd_y_ff <= mem_y[cmd.idx];
      end
      if (cmd.shift_wr) begin
         mem_x[cmd.idx] <= rd_x_ff;
         mem_y[cmd.idx] <= rd_y_ff;
      end else if (cmd.place) begin
         mem_x[cmd.idx] <= new_x_ff;
         mem_y[cmd.idx] <= new_y_ff;
      end
   end

   assign ddx = {bx_ff[plt_pkg::CoordW-1], bx_ff} - {ax_ff[plt_pkg::CoordW-1], ax_ff};
   assign ddy = {by_ff[plt_pkg::CoordW-1], by_ff} - {ay_ff[plt_pkg::CoordW-1], ay_ff};

   // One radicand bit pair per cycle: classic restoring square root.
   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff >> 1;
      if (rem_ff >= root_ff + bit_ff) begin
         rem_in  = rem_ff - (root_ff + bit_ff);
         root_in = (root_ff >> 1) + bit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_a) begin
         ax_ff <= rd_x_ff;
         ay_ff <= rd_y_ff;
      end
      if (cmd.cap_b) begin
         bx_ff <= rd_x_ff;
         by_ff <= rd_y_ff;
      end
      if (cmd.diff) begin
         dx_ff <= ddx[plt_pkg::CoordW] ? (plt_pkg::CoordW + 1)'(0) - ddx : ddx;
         dy_ff <= ddy[plt_pkg::CoordW] ? (plt_pkg::CoordW + 1)'(0) - ddy : ddy;
      end
      if (cmd.square) begin
         sq_ff <= plt_pkg::SqW'(dx_ff * dx_ff) + plt_pkg::SqW'(dy_ff * dy_ff);
      end
      if (cmd.root_start) begin
         rem_ff   <= sq_ff;
         root_ff  <= '0;
         bit_ff   <= plt_pkg::SqW'(1) << (plt_pkg::SqW - 2);
         steps_ff <= 6'(plt_pkg::RootSteps);
      end else if (cmd.root_step) begin
         rem_ff   <= rem_in;
         root_ff  <= root_in;
         bit_ff   <= bit_ff >> 2;
         steps_ff <= steps_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         full_ff <= 1'b0;
      end else begin
         if (cmd.load) full_ff <= cmd.full;
         if (cmd.clr_sum) begin
            sum_ff <= '0;
         end else if (cmd.acc) begin
            if ({1'b0, sum_ff} + (plt_pkg::TotW + 1)'(root_ff[plt_pkg::SegW-1:0])
                > {1'b0, {plt_pkg::TotW{1'b1}}})
               sum_ff <= '1;
            else
               sum_ff <= sum_ff + plt_pkg::TotW'(root_ff[plt_pkg::SegW-1:0]);
         end
      end
   end

   // Output register: holds the finished word while the next pass runs.
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_total_ff <= sum_ff;
         out_full_ff  <= full_ff;
      end
   end

   assign status.root_done = (steps_ff == 6'd0);
   assign sum_out  = out_total_ff;
   assign full_out = out_full_ff;

endmodule

### sv/plt_controller.sv
// ----------------------------------------------------------------------------
// Polyline length table controller
// Sequences the insert shift, the placement and the per-segment length pass.
// ----------------------------------------------------------------------------
`include "polyline_length_table_defines.svh"

module plt_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [plt_pkg::IdxW:0]        req_insert_position,
   input  logic                          closed_mode,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [plt_pkg::CntW-1:0]      count_out,
   output plt_pkg::cmd_type              cmd,
   input  plt_pkg::status_type           status
);

   plt_pkg::state_type          state_ff, state_in;
   logic [plt_pkg::CntW-1:0]    count_ff, pos_ff, idx_ff, nseg_ff, rsp_count_ff;
   logic [plt_pkg::CntW-1:0]    count_in, pos_in, idx_in, nseg_in, rsp_count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        accept, full_now;
   logic [plt_pkg::CntW-1:0]    next_idx;

   assign accept   = req_valid && !req_stall;
   assign full_now = count_ff >= plt_pkg::CntW'(plt_pkg::MaxPoints);
   assign next_idx = (idx_ff + 1'b1 < count_ff) ? idx_ff + 1'b1 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      idx_ff       <= idx_in;
      nseg_ff      <= nseg_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Next state and counters.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      nseg_in      = nseg_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         plt_pkg::ST_IDLE: begin
            if (accept) begin
               pos_in = (req_insert_position > count_ff) ? count_ff : req_insert_position;
               idx_in = count_ff;
               state_in = full_now ? plt_pkg::ST_SEG_START : plt_pkg::ST_SHIFT_RD;
            end
         end
         plt_pkg::ST_SHIFT_RD: begin
            state_in = (idx_ff > pos_ff) ? plt_pkg::ST_SHIFT_WR : plt_pkg::ST_PLACE;
         end
         plt_pkg::ST_SHIFT_WR: begin
            idx_in   = idx_ff - 1'b1;
            state_in = plt_pkg::ST_SHIFT_RD;
         end
         plt_pkg::ST_PLACE: begin
            count_in = count_ff + 1'b1;
            state_in = plt_pkg::ST_SEG_START;
         end
         plt_pkg::ST_SEG_START: begin
            idx_in  = '0;
            nseg_in = closed_mode ? count_ff : count_ff - 1'b1;
            state_in = (count_ff == '0 || (!closed_mode && count_ff == plt_pkg::CntW'(1)))
                       ? plt_pkg::ST_RESULT : plt_pkg::ST_RD_A;
         end
         plt_pkg::ST_RD_A:      state_in = plt_pkg::ST_RD_B;
         plt_pkg::ST_RD_B:      state_in = plt_pkg::ST_CAP_B;
         plt_pkg::ST_CAP_B:     state_in = plt_pkg::ST_DIFF;
         plt_pkg::ST_DIFF:      state_in = plt_pkg::ST_SQ;
         plt_pkg::ST_SQ:        state_in = plt_pkg::ST_ROOT_INIT;
         plt_pkg::ST_ROOT_INIT: state_in = plt_pkg::ST_ROOT;
         plt_pkg::ST_ROOT: begin
            if (status.root_done) state_in = plt_pkg::ST_ACC;
         end
         plt_pkg::ST_ACC: begin
            idx_in   = idx_ff + 1'b1;
            state_in = (idx_ff + 1'b1 >= nseg_ff) ? plt_pkg::ST_RESULT : plt_pkg::ST_RD_A;
         end
         plt_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               state_in     = plt_pkg::ST_IDLE;
            end
         end
         default: state_in = plt_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd       = '0;
      cmd.idx   = idx_ff[plt_pkg::IdxW-1:0];
      cmd.full  = full_now;
      unique case (state_ff)
         plt_pkg::ST_IDLE:      begin
            cmd.load    = accept;
            cmd.clr_sum = accept;
         end
         plt_pkg::ST_SHIFT_RD:  begin
            cmd.shift_rd = 1'b1;
            cmd.idx      = plt_pkg::IdxW'(idx_ff - 1'b1);
         end
         plt_pkg::ST_SHIFT_WR:  cmd.shift_wr = 1'b1;
         plt_pkg::ST_PLACE:     begin
            cmd.place = 1'b1;
            cmd.idx   = pos_ff[plt_pkg::IdxW-1:0];
         end
         plt_pkg::ST_SEG_START: ;
         plt_pkg::ST_RD_A:      cmd.rd_vertex = 1'b1;
         plt_pkg::ST_RD_B:      begin
            cmd.cap_a     = 1'b1;
            cmd.rd_vertex = 1'b1;
            cmd.idx       = next_idx[plt_pkg::IdxW-1:0];
         end
         plt_pkg::ST_CAP_B:     cmd.cap_b = 1'b1;
         plt_pkg::ST_DIFF:      cmd.diff = 1'b1;
         plt_pkg::ST_SQ:        cmd.square = 1'b1;
         plt_pkg::ST_ROOT_INIT: cmd.root_start = 1'b1;
         plt_pkg::ST_ROOT:      cmd.root_step = !status.root_done;
         plt_pkg::ST_ACC:       cmd.acc = 1'b1;
         plt_pkg::ST_RESULT:    cmd.publish = !rsp_valid_ff || !rsp_stall;
         default:               ;
      endcase
   end

   assign req_stall = (state_ff != plt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign count_out = rsp_count_ff;

   `PLT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      count_ff <= plt_pkg::CntW'(plt_pkg::MaxPoints), "vertex count beyond table size")
   `PLT_ASSERT_NEXT(a_full_no_grow, clock, reset, accept && full_now,
      $stable(count_ff), "full table grew")
   `PLT_ASSERT_IMP(a_shift_range, clock, reset, state_ff == plt_pkg::ST_SHIFT_WR,
      idx_ff > pos_ff && idx_ff != '0, "shift beyond insert point")

endmodule

### sv/polyline_length_table.sv
// ----------------------------------------------------------------------------
// Polyline length table
// Inserts vertices into a table and reports the polyline's total length.
// ----------------------------------------------------------------------------
//  channel   direction  words
//  req_      in         point_x, point_y, insert_position
//  rsp_      out        total_length, point_count, table_full
//  csr_      in         closed_mode (write only)
//
//  An insert into a table that is not full shifts the vertex memories through
//  their single port and places the vertex; every insert then runs each
//  segment through two reads, a capture, the difference, the square, the root
//  set-up, the 25-step serial square root and the accumulate; a full table
//  has up to 256 segments.
//  Reset clears the count and sets closed mode; vertex memories are not cleared.
//  A new word is taken only when the previous pass has finished; its result
//  waits in the output register, and the next pass holds in its last state
//  only if that register is still occupied.
// ----------------------------------------------------------------------------
module polyline_length_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [plt_pkg::CoordW-1:0] req_point_x,
   input  logic signed [plt_pkg::CoordW-1:0] req_point_y,
   input  logic [8:0]                        req_insert_position,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [plt_pkg::TotW-1:0]          rsp_total_length,
   output logic [8:0]                        rsp_point_count,
   output logic                              rsp_table_full,
   input  logic                              csr_write_enable,
   input  logic                              csr_write_data
);

   plt_pkg::cmd_type    cmd;
   plt_pkg::status_type status;
   logic                closed_ff;
   logic [plt_pkg::CntW-1:0] count;

   // The mode register is to be written only while the block is idle; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) closed_ff <= 1'b1;
      else if (csr_write_enable) closed_ff <= csr_write_data;
   end

   plt_controller u_ctrl (
      .clock, .reset, .req_valid, .req_stall,
      .req_insert_position, .closed_mode(closed_ff),
      .rsp_valid, .rsp_stall, .count_out(count), .cmd, .status
   );

   plt_datapath u_dp (
      .clock, .reset, .cmd, .status, .req_point_x, .req_point_y,
      .sum_out(rsp_total_length), .full_out(rsp_table_full)
   );

   // The sum, the count and the flag are held in output registers until the
   // word has been taken.
   assign rsp_point_count = count;

endmodule

### verif/polyline_length_table_tb.sv
// ----------------------------------------------------------------------------
// Polyline length table testbench
// Inserts vertices through the request channel and checks every response word
// (total length, vertex count, full flag) against a local model of the table or a typed-in answer.
// A short directed table comes first, then random inserts that fill the table
// and go on past full, with the open and closed modes switched between phases.
// ----------------------------------------------------------------------------
module polyline_length_table_tb;

   localparam int WatchdogLimit = 60000;
   localparam int SettleCycles  = 60;
   localparam int ReportLimit   = 10;
   localparam int ItemsPastFull = 530;
   localparam int PhaseLength   = 60;

   typedef struct packed {
      logic [plt_pkg::TotW-1:0] total;
      logic [8:0]               count;
      logic                     full;
   } length_word_type;

   typedef struct {
      logic                              closed;
      logic signed [plt_pkg::CoordW-1:0] x;
      logic signed [plt_pkg::CoordW-1:0] y;
      logic [8:0]                        pos;
      logic                              typed;
      length_word_type                   want;
   } stim_row_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic signed [plt_pkg::CoordW-1:0] req_point_x;
   logic signed [plt_pkg::CoordW-1:0] req_point_y;
   logic [8:0]                        req_insert_position;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [plt_pkg::TotW-1:0]          rsp_total_length;
   logic [8:0]                        rsp_point_count;
   logic                              rsp_table_full;
   logic                              csr_write_enable;
   logic                              csr_write_data;

   // Local copy of the table, used to work out what each insert should report.
   logic signed [plt_pkg::CoordW-1:0] model_x [plt_pkg::MaxPoints];
   logic signed [plt_pkg::CoordW-1:0] model_y [plt_pkg::MaxPoints];
   int unsigned              model_count;
   logic                     model_closed;

   length_word_type pending_lengths [$];
   stim_row_type    directed_rows [10];

   int  mismatches = 0;
   int  words_sent;
   int  words_checked = 0;
   int  rejected_inserts;
   int  mode_writes;
   int  stall_left = 0;
   int  idle_cycles = 0;
   bit  quiet;

   polyline_length_table dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_point_x         (req_point_x),
      .req_point_y         (req_point_y),
      .req_insert_position (req_insert_position),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_total_length    (rsp_total_length),
      .rsp_point_count     (rsp_point_count),
      .rsp_table_full      (rsp_table_full),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor of the square root, by the classic bit-pair method.
   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bitval;
      root   = 0;
      bitval = 64'd1 << 62;
      while (bitval > n) bitval = bitval >> 2;
      while (bitval != 0) begin
         if (n >= root + bitval) begin
            n    = n - (root + bitval);
            root = (root >> 1) + bitval;
         end else begin
            root = root >> 1;
         end
         bitval = bitval >> 2;
      end
      return root;
   endfunction

   function automatic logic [plt_pkg::SegW-1:0] segment_length(int unsigned a,
                                                               int unsigned b);
      longint          dx;
      longint          dy;
      longint unsigned ux;
      longint unsigned uy;
      dx = longint'(model_x[b]) - longint'(model_x[a]);
      dy = longint'(model_y[b]) - longint'(model_y[a]);
      ux = (dx < 0) ? -dx : dx;
      uy = (dy < 0) ? -dy : dy;
      return plt_pkg::SegW'(floor_sqrt(ux * ux + uy * uy));
   endfunction

   // Applies one insert to the local table and returns the word it should cause.
   function automatic length_word_type insert_vertex(
         logic signed [plt_pkg::CoordW-1:0] x,
         logic signed [plt_pkg::CoordW-1:0] y,
         logic [8:0] pos);
      length_word_type word;
      int unsigned     at;
      int unsigned     segments;
      int unsigned     next;
      longint unsigned sum;
      word.full = (model_count >= plt_pkg::MaxPoints);
      if (!word.full) begin
         at = (pos > model_count) ? model_count : pos;
         for (int i = model_count; i > at; i--) begin
            model_x[i] = model_x[i-1];
            model_y[i] = model_y[i-1];
         end
         model_x[at] = x;
         model_y[at] = y;
         model_count++;
      end
      // The closing segment only exists in closed mode; a lone vertex in closed
      // mode has one segment of length zero back to itself.
      sum = 0;
      if (model_count != 0) begin
         segments = model_closed ? model_count : model_count - 1;
         for (int unsigned i = 0; i < segments; i++) begin
            next = (i + 1 < model_count) ? i + 1 : 0;
            sum  = sum + segment_length(i, next);
            if (sum > 64'h1_FFFF_FFFF) sum = 64'h1_FFFF_FFFF;
         end
      end
      word.total = sum[plt_pkg::TotW-1:0];
      word.count = model_count[8:0];
      return word;
   endfunction

   // Coordinates are drawn from the extremes, near zero or anywhere at all.
   function automatic logic signed [plt_pkg::CoordW-1:0] pick_coord();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
         1:       return plt_pkg::CoordW'($urandom_range(0, 4095) - 2048);
         2:       return plt_pkg::CoordW'($urandom_range(0, 262143) - 131072);
         default: return plt_pkg::CoordW'($urandom);
      endcase
   endfunction

   function automatic logic [8:0] pick_position();
      case ($urandom_range(0, 3))
         0:       return 9'd0;
         1:       return 9'($urandom_range(0, model_count));
         2:       return 9'($urandom_range(0, 511));
         default: return model_count[8:0];
      endcase
   endfunction

   // Presents one word after a random gap and waits for the block to take it.
   // The valid stays high when the gap is zero, so it is never lowered and
   // raised again within the same edge.
   task automatic send_insert(logic signed [plt_pkg::CoordW-1:0] x,
                              logic signed [plt_pkg::CoordW-1:0] y,
                              logic [8:0] pos, logic typed, length_word_type want);
      int              gap;
      length_word_type predicted;
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_point_x         <= x;
      req_point_y         <= y;
      req_insert_position <= pos;
      req_valid           <= 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = insert_vertex(x, y, pos);
      if (predicted.full) rejected_inserts++;
      pending_lengths.push_back(typed ? want : predicted);
      words_sent++;
   endtask

   // Mode writes happen only with the block idle: every word has come back and
   // a short settling pause has passed.
   task automatic write_mode(logic closed);
      req_valid <= 1'b0;
      while (pending_lengths.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= closed;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_closed = closed;
      mode_writes++;
   endtask

   // Response side: stalls for a random number of cycles before each word and
   // checks every accepted word against the oldest outstanding expectation.
   always @(posedge clock) begin
      length_word_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_lengths.size() == 0) begin
               mismatches++;
               if (mismatches <= ReportLimit)
                  $display("unexpected response word: total %0d count %0d full %0d",
                           rsp_total_length, rsp_point_count, rsp_table_full);
            end else begin
               want = pending_lengths.pop_front();
               words_checked++;
               if (want.total !== rsp_total_length || want.count !== rsp_point_count ||
                   want.full !== rsp_table_full) begin
                  mismatches++;
                  if (mismatches <= ReportLimit)
                     $display({"word %0d mismatch: expected total %0d count %0d full %0d,",
                               " got total %0d count %0d full %0d"},
                              words_checked, want.total, want.count, want.full,
                              rsp_total_length, rsp_point_count, rsp_table_full);
               end
            end
            stall_left = quiet ? 0 : $urandom_range(0, 8);
            rsp_stall <= (stall_left != 0);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= (stall_left != 0);
         end
      end
   end

   // Watchdog: the run is stuck if no word moves on either side for too long.
   // An insert into a full table runs a length pass over every segment, hence the margin.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int past_full;
      int in_phase;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_point_x         = '0;
      req_point_y         = '0;
      req_insert_position = '0;
      csr_write_enable    = 1'b0;
      csr_write_data      = 1'b0;
      model_count         = 0;
      model_closed        = 1'b1;
      words_sent          = 0;
      rejected_inserts    = 0;
      mode_writes         = 0;
      quiet               = 1'b0;

      // Directed rows. Only the first two have their answer typed in: a lone
      // vertex gives zero, and a 3-4-5 step scaled by 256 closed back on itself gives twice 1280.
      directed_rows[0] = '{1'b1, 24'sd0, 24'sd0, 9'd0, 1'b1, '{33'd0, 9'd1, 1'b0}};
      directed_rows[1] = '{1'b1, 24'sd768, 24'sd1024, 9'd511, 1'b1, '{33'd2560, 9'd2, 1'b0}};
      directed_rows[2] = '{1'b0, 24'sh7FFFFF, 24'sh7FFFFF, 9'd0, 1'b0, '0};
      directed_rows[3] = '{1'b0, 24'sh800000, 24'sh800000, 9'd1, 1'b0, '0};
      directed_rows[4] = '{1'b0, 24'sh800000, 24'sh7FFFFF, 9'd256, 1'b0, '0};
      directed_rows[5] = '{1'b0, 24'sh7FFFFF, 24'sh800000, 9'd2, 1'b0, '0};
      directed_rows[6] = '{1'b1, -24'sd1, -24'sd1, 9'd0, 1'b0, '0};
      directed_rows[7] = '{1'b1, 24'sd256, 24'sd0, 9'd3, 1'b0, '0};
      directed_rows[8] = '{1'b1, 24'sd0, -24'sd256, 9'd5, 1'b0, '0};
      directed_rows[9] = '{1'b0, -24'sd5, 24'sd7, 9'd1, 1'b0, '0};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].closed !== model_closed) write_mode(directed_rows[i].closed);
         send_insert(directed_rows[i].x, directed_rows[i].y, directed_rows[i].pos,
                     directed_rows[i].typed, directed_rows[i].want);
      end

      // Random part. The table only grows, and every insert into a large table
      // runs a length pass over every segment, so the run fills the table once
      // and then carries on with several hundred rejected inserts. Each phase
      // flips the mode and sometimes runs with no idling at all.
      past_full = 0;
      in_phase  = 0;
      while (past_full < ItemsPastFull) begin
         if (in_phase == PhaseLength) begin
            write_mode(!model_closed);
            quiet    = ($urandom_range(0, 3) == 0);
            in_phase = 0;
         end
         if (model_count >= plt_pkg::MaxPoints) past_full++;
         send_insert(pick_coord(), pick_coord(), pick_position(), 1'b0, '0);
         in_phase++;
      end
      write_mode(1'b0);
      send_insert(pick_coord(), pick_coord(), pick_position(), 1'b0, '0);
      write_mode(1'b1);
      send_insert(pick_coord(), pick_coord(), pick_position(), 1'b0, '0);

      req_valid <= 1'b0;
      while (pending_lengths.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("%0d inserts sent, %0d words checked, %0d rejected on a full table",
               words_sent, words_checked, rejected_inserts);
      $display("%0d mode writes, %0d mismatches", mode_writes, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
